[rtl/sha256_sha224_hash_unit_macros.svh]
// Assertion helpers for the hash unit
`ifndef SHA256_SHA224_HASH_UNIT_MACROS_SVH
`define SHA256_SHA224_HASH_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the following cycle
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sha_pkg.sv]
package sha_pkg;

  localparam int WordW = 32;
  localparam int DefRounds = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } sha_state_t;

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // Initial hash values per mode
  function automatic logic [31:0] init_value(input logic mode, input logic [2:0] idx);
    logic [31:0] v;
    case ({mode, idx})
      4'd0: v = 32'h6a09e667; 4'd1: v = 32'hbb67ae85; 4'd2: v = 32'h3c6ef372;
      4'd3: v = 32'ha54ff53a; 4'd4: v = 32'h510e527f; 4'd5: v = 32'h9b05688c;
      4'd6: v = 32'h1f83d9ab; 4'd7: v = 32'h5be0cd19; 4'd8: v = 32'hc1059ed8;
      4'd9: v = 32'h367cd507; 4'd10: v = 32'h3070dd17; 4'd11: v = 32'hf70e5939;
      4'd12: v = 32'hffc00b31; 4'd13: v = 32'h68581511; 4'd14: v = 32'h64f98fa7;
      default: v = 32'hbefa4fa4;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
    return (x >> r) | (x << (32 - r));
  endfunction

endpackage

[rtl/sha_round.sv]
module sha_round (
  input  logic [255:0] vars,
  input  logic [31:0]  w,
  input  logic [31:0]  k,
  output logic [255:0] vars_next
);
  import sha_pkg::*;

  logic [31:0] a, b, c, d, e, f, g, h, t1, t2;

  // One compression round over a..h
  always_comb begin
    {h, g, f, e, d, c, b, a} = vars;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + k + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    vars_next = {g, f, e, d + t1, c, b, a, t1 + t2};
  end
endmodule

[rtl/sha_schedule.sv]
module sha_schedule (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] load_word,
  input  logic        shift,
  output logic [31:0] w
);
  import sha_pkg::*;

  logic [31:0] win [16];
  logic [31:0] s0, s1, wnew;

  // Head of the window is the current round word
  always_comb begin
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    wnew = win[0] + s0 + win[9] + s1;
    w = win[0];
  end

  // Shift words in at the tail, one per load or round
  always_ff @(posedge clk) begin
    if (load || shift) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= load ? load_word : wnew;
    end
  end
endmodule

[rtl/sha256_sha224_hash_unit.sv]
// SHA-256 / SHA-224 hasher. Message words enter on s_axis (tdata: data_word[31:0],
// byte_count[34:32], tuser: last_word); padding is added internally. Padding words
// are written into the message schedule from ST_PAD while input is held off. Every
// 16th word (and each padding-generated block) starts a compression of ROUNDS rounds
// through one shared round unit, followed by the hash add. s_axis_tready is low during
// padding, compression, the hash add and digest output. After the last word the
// digest leaves on m_axis, one beat per cycle while m_axis_tready is high: eight
// words (SHA-256) or seven (SHA-224), tlast on the final one. cfg writes select the
// mode and restart the message; s_axis_tready is held low while cfg_valid is high.
module sha256_sha224_hash_unit #(
  parameter int ROUNDS = sha_pkg::DefRounds
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // data_word[31:0], byte_count[34:32], zero fill
  input  logic        s_axis_tuser,   // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word[31:0]
  output logic        m_axis_tlast    // digest_last
);
  import sha_pkg::*;

  localparam int RW = $clog2(ROUNDS);

  sha_state_t state, state_next;
  logic         mode;
  logic [255:0] hs, vars, vars_next;
  logic [3:0]   wcount;
  logic [RW-1:0] rnd;
  logic [63:0]  bitlen;
  logic [1:0]   pad_phase;   // 0 body zeros, 1 length high, 2 length low, 3 marker word
  logic         pad_active;
  logic         final_blk;
  logic [2:0]   out_idx;
  logic         load, shift;
  logic [31:0]  load_word, w;
  logic [31:0]  in_data;
  logic [2:0]   in_cnt, n;
  logic [31:0]  mask, last_word_val, pad_word;
  logic         acc;

  assign in_data = s_axis_tdata[31:0];
  assign in_cnt  = s_axis_tdata[34:32];
  assign n = (in_cnt > 3'd4) ? 3'd4 : in_cnt;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;

  // Masked final word with the 0x80 marker
  always_comb begin
    case (n)
      3'd0: begin mask = 32'h0; pad_word = 32'h80000000; end
      3'd1: begin mask = 32'hff000000; pad_word = 32'h00800000; end
      3'd2: begin mask = 32'hffff0000; pad_word = 32'h00008000; end
      3'd3: begin mask = 32'hffffff00; pad_word = 32'h00000080; end
      default: begin mask = 32'hffffffff; pad_word = 32'h0; end
    endcase
    last_word_val = (in_data & mask) | pad_word;
  end

  sha_schedule u_sched (.clk(clk), .load(load), .load_word(load_word),
                        .shift(shift), .w(w));
  sha_round u_round (.vars(vars), .w(w), .k(round_k(rnd[5:0])), .vars_next(vars_next));

  // Sequencer
  always_comb begin
    state_next = state;
    load = 1'b0;
    shift = 1'b0;
    load_word = in_data;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          load = 1'b1;
          load_word = (s_axis_tuser && n != 3'd4) ? last_word_val : in_data;
          if (wcount == 4'd15) state_next = ST_ROUND;
          else if (s_axis_tuser) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        load = 1'b1;
        load_word = (pad_phase == 2'd3) ? 32'h80000000 :
                    (pad_phase == 2'd1) ? bitlen[63:32] :
                    (pad_phase == 2'd2) ? bitlen[31:0] : 32'h0;
        if (wcount == 4'd15) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        shift = 1'b1;
        if (rnd == RW'(ROUNDS - 1)) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (final_blk) state_next = ST_EMIT;
        else if (pad_active) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (m_axis_tready && m_axis_tlast) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      for (int i = 0; i < 8; i++) hs[32*i +: 32] <= init_value(1'b0, 3'(i));
      vars <= '0;
      wcount <= '0;
      rnd <= '0;
      bitlen <= '0;
      pad_phase <= '0;
      pad_active <= 1'b0;
      final_blk <= 1'b0;
      out_idx <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
        for (int i = 0; i < 8; i++) hs[32*i +: 32] <= init_value(cfg_data, 3'(i));
        wcount <= '0;
        bitlen <= '0;
      end
      case (state)
        ST_IDLE: if (acc) begin
          wcount <= wcount + 4'd1;
          if (!s_axis_tuser) bitlen <= bitlen + 64'd32;
          else begin
            bitlen <= bitlen + {58'd0, n, 3'd0};
            pad_active <= 1'b1;
            // full last word: marker word still to push
            pad_phase <= (n == 3'd4) ? 2'd3 : ((wcount == 4'd13) ? 2'd1 : 2'd0);
          end
          if (wcount == 4'd15) vars <= hs;
        end
        ST_PAD: begin
          wcount <= wcount + 4'd1;
          case (pad_phase)
            2'd3: pad_phase <= (wcount == 4'd13) ? 2'd1 : 2'd0;
            2'd0: if (wcount == 4'd13) pad_phase <= 2'd1;
            2'd1: pad_phase <= 2'd2;
            default: begin pad_phase <= 2'd0; final_blk <= 1'b1; end
          endcase
          if (wcount == 4'd15) vars <= hs;
        end
        ST_ROUND: begin
          vars <= vars_next;
          rnd <= (rnd == RW'(ROUNDS - 1)) ? '0 : rnd + RW'(1);
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) hs[32*i +: 32] <= hs[32*i +: 32] + vars[32*i +: 32];
          out_idx <= '0;
        end
        ST_EMIT: if (m_axis_tready) begin
          out_idx <= out_idx + 3'd1;
          if (m_axis_tlast) begin
            for (int i = 0; i < 8; i++) hs[32*i +: 32] <= init_value(mode, 3'(i));
            bitlen <= '0;
            wcount <= '0;
            final_blk <= 1'b0;
            pad_active <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ST_PAD when pad_phase==3 pushes the marker word
  assign m_axis_tvalid = (state == ST_EMIT);
  assign m_axis_tdata  = hs[32*out_idx +: 32];
  assign m_axis_tlast  = (out_idx == (mode ? 3'd6 : 3'd7));
endmodule

[rtl/sha_checker.sv]
module sha_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic cfg_ready
);
`include "sha256_sha224_hash_unit_macros.svh"

  `SHA_ASSERT_IMP(no_in_during_out, m_axis_tvalid, !s_axis_tready, "input open during digest")
  `SHA_ASSERT_NEXT(busy_after_block, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "ready after last word")
  `SHA_ASSERT_NEXT(out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "digest beat dropped")
  `SHA_ASSERT_IMP(in_only_idle, s_axis_tready, cfg_ready, "input open while busy")
endmodule

bind sha256_sha224_hash_unit sha_checker u_chk (.*);
